FILE: rtl/fac_pkg.sv
// Shared types and constants for the frustum box cull unit.
package fac_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NUM_PLANES = 6;
    // plane components are sums of two coordinates
    localparam int PL_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS  = PL_BITS + COORD_BITS;
    // four terms per plane
    localparam int SUM_BITS   = PROD_BITS + 2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    // comp[0..2] is the normal, comp[3] is d; corner is the picked box corner
    typedef struct packed {
        logic [3:0][PL_BITS-1:0]    comp;
        logic [2:0][COORD_BITS-1:0] corner;
    } t_plane;

    typedef struct packed {
        logic                          was_test;
        t_plane [NUM_PLANES-1:0]       planes;
    } t_job;

endpackage

FILE: rtl/fac_in_if.sv
// Input channel: matrix loads and box tests.
interface fac_in_if import fac_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [1:0]                   vec_index;
    logic signed [COORD_BITS-1:0] vec_x;
    logic signed [COORD_BITS-1:0] vec_y;
    logic signed [COORD_BITS-1:0] vec_z;
    logic signed [COORD_BITS-1:0] vec_w;
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] min_z;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] max_y;
    logic signed [COORD_BITS-1:0] max_z;

    modport source (
        output valid, func, vec_index, vec_x, vec_y, vec_z, vec_w,
               min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );
    modport sink (
        input  valid, func, vec_index, vec_x, vec_y, vec_z, vec_w,
               min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );
endinterface

FILE: rtl/fac_out_if.sv
// Output channel: one result per input item.
interface fac_out_if import fac_pkg::*; ();
    logic valid;
    logic ready;
    logic visible;
    logic was_test;

    modport source (output valid, visible, was_test, input ready);
    modport sink (input valid, visible, was_test, output ready);
endinterface

FILE: rtl/fac_front.sv
// Front end: holds the matrix, forms the six planes and picks box corners.
module fac_front import fac_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    fac_in_if.sink  i_in,
    output logic    o_push,
    output t_job    o_job,
    input  logic    i_full
);

    logic [3:0][3:0][COORD_BITS-1:0] r_mat;
    logic [2:0][COORD_BITS-1:0]      bmin;
    logic [2:0][COORD_BITS-1:0]      bmax;
    logic                            xfer;

    assign i_in.ready = !i_full;
    assign xfer       = i_in.valid && !i_full;
    assign o_push     = xfer;

    assign bmin = {i_in.min_z, i_in.min_y, i_in.min_x};
    assign bmax = {i_in.max_z, i_in.max_y, i_in.max_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '0;
        end else if (xfer && i_in.func == FUNC_LOAD) begin
            r_mat[i_in.vec_index] <= {i_in.vec_w, i_in.vec_z, i_in.vec_y, i_in.vec_x};
        end
    end

    // plane p uses row p/2, subtracted for odd p
    always_comb begin
        logic [PL_BITS-1:0] a_ext;
        logic [PL_BITS-1:0] b_ext;
        logic [PL_BITS-1:0] sum;
        o_job.was_test = i_in.func;
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int e = 0; e < 4; e++) begin
                a_ext = {r_mat[3][e][COORD_BITS-1], r_mat[3][e]};
                b_ext = {r_mat[p >> 1][e][COORD_BITS-1], r_mat[p >> 1][e]};
                sum   = ((p & 1) != 0) ? a_ext - b_ext : a_ext + b_ext;
                o_job.planes[p].comp[e] = sum;
            end
            for (int e = 0; e < 3; e++) begin
                o_job.planes[p].corner[e] = o_job.planes[p].comp[e][PL_BITS-1] ?
                                            bmin[e] : bmax[e];
            end
        end
    end

endmodule

FILE: rtl/fac_fifo.sv
// Short job queue between the front end and the back end.
module fac_fifo import fac_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/fac_back.sv
// Back end: plane products, then sums, sign test and the output register.
module fac_back import fac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_q_job,
    output logic      o_pop,
    fac_out_if.source o_out
);

    logic                                   en;
    logic                                   r_s1_valid;
    logic                                   r_s1_test;
    logic [NUM_PLANES-1:0][3:0][PROD_BITS-1:0] r_s1_terms;
    logic [NUM_PLANES-1:0][3:0][PROD_BITS-1:0] n_terms;
    logic                                   r_out_valid;
    logic                                   r_out_visible;
    logic                                   r_out_test;
    logic                                   n_visible;

    // whole back end stalls only when a result sits unaccepted
    assign en    = !r_out_valid || o_out.ready;
    assign o_pop = en && i_q_valid;

    always_comb begin
        logic [PL_BITS-1:0] d;
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int e = 0; e < 3; e++) begin
                n_terms[p][e] = $signed(i_q_job.planes[p].comp[e]) *
                                $signed(i_q_job.planes[p].corner[e]);
            end
            d = i_q_job.planes[p].comp[3];
            // d moved up to Q33.32
            n_terms[p][3] = {{(PROD_BITS - PL_BITS - FRAC_BITS){d[PL_BITS-1]}}, d,
                             {FRAC_BITS{1'b0}}};
        end
    end

    always_comb begin
        logic [SUM_BITS-1:0] sum;
        n_visible = 1'b1;
        for (int p = 0; p < NUM_PLANES; p++) begin
            sum = '0;
            for (int e = 0; e < 4; e++) begin
                sum = sum + {{(SUM_BITS - PROD_BITS){r_s1_terms[p][e][PROD_BITS-1]}},
                             r_s1_terms[p][e]};
            end
            if (sum[SUM_BITS-1]) begin
                n_visible = 1'b0;
            end
        end
        if (r_s1_test == FUNC_LOAD) begin
            n_visible = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_terms    <= n_terms;
            r_s1_test     <= i_q_job.was_test;
            r_out_visible <= n_visible;
            r_out_test    <= r_s1_test;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_q_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.visible  = r_out_visible;
    assign o_out.was_test = r_out_test;

endmodule

FILE: rtl/frustum_aabb_cull_unit.sv
// One item per cycle while output is ready; each transfer yields exactly one result.
// Each result passes the queue write, the product stage, then the sum and sign
// test into the output register.
// The job queue (QUEUE_DEPTH entries) lets input keep flowing while a result waits.
// Reset clears the stored matrix to zero, so every box tests visible until loaded.
module frustum_aabb_cull_unit import fac_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fac_in_if.sink    i_in,
    fac_out_if.source o_out
);

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_job push_job;
    t_job q_job;

    fac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    fac_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    fac_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
